FILE: hdl/tse_pkg.sv
// ----------------------------------------------------------------------------
// Elapsed time package
// Field widths, request and result types, internal stage types, the
// reciprocal constants used for division by constants, and the month table.
// ----------------------------------------------------------------------------
package tse_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned HOURS_W  = 27;

  localparam int unsigned DAYS_W = 23;
  localparam int unsigned TOD_W  = 17;
  localparam int unsigned REM_W  = 12;

  localparam int unsigned MAX_YEAR = 9999;

  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned HOURS_PER_DAY = 24;

  // Division by 25, 225 and 15 as a multiply by a rounded-up reciprocal.
  localparam int unsigned RECIP_25        = 5243;
  localparam int unsigned RECIP_25_SHIFT  = 17;
  localparam int unsigned RECIP_225       = 4661;
  localparam int unsigned RECIP_225_SHIFT = 20;
  localparam int unsigned RECIP_15        = 1093;
  localparam int unsigned RECIP_15_SHIFT  = 14;

  typedef struct packed {
    logic [YEAR_W-1:0]   first_year;
    logic [MONTH_W-1:0]  first_month;
    logic [DAY_W-1:0]    first_day;
    logic [HOUR_W-1:0]   first_hour;
    logic [MINUTE_W-1:0] first_minute;
    logic [SECOND_W-1:0] first_second;
    logic [YEAR_W-1:0]   second_year;
    logic [MONTH_W-1:0]  second_month;
    logic [DAY_W-1:0]    second_day;
    logic [HOUR_W-1:0]   second_hour;
    logic [MINUTE_W-1:0] second_minute;
    logic [SECOND_W-1:0] second_second;
  } stamps_t;

  typedef struct packed {
    logic [HOURS_W-1:0]  elapsed_hours;
    logic [MINUTE_W-1:0] elapsed_minutes;
    logic [SECOND_W-1:0] elapsed_seconds;
    logic                invalid;
  } elapsed_t;

  typedef struct packed {
    logic              bad;
    logic [DAYS_W-1:0] days_a;
    logic [DAYS_W-1:0] days_b;
    logic [TOD_W-1:0]  tod_a;
    logic [TOD_W-1:0]  tod_b;
  } span_t;

  typedef struct packed {
    logic              bad;
    logic [DAYS_W-1:0] days;
    logic [TOD_W-1:0]  tod;
  } delta_t;

  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] month);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: hdl/tse_days.sv
// ----------------------------------------------------------------------------
// Day count stages
// Three register stages that turn each timestamp into a day count since
// 0001-01-01 and seconds of the day, and check field ranges (the day only for zero).
// ----------------------------------------------------------------------------
module tse_days #(
  parameter int unsigned MAX_YEAR = tse_pkg::MAX_YEAR
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  tse_pkg::stamps_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output tse_pkg::span_t  rsp
);
  import tse_pkg::*;

  logic [YEAR_W-1:0]   yr [2];
  logic [MONTH_W-1:0]  mo [2];
  logic [DAY_W-1:0]    dy [2];
  logic [HOUR_W-1:0]   hr [2];
  logic [MINUTE_W-1:0] mi [2];
  logic [SECOND_W-1:0] sc [2];
  logic [YEAR_W-1:0]   p [2];
  logic [24:0]         prod100 [2];
  logic [22:0]         prod400 [2];
  logic [26:0]         prod25 [2];
  logic                bad_c [2];
  logic                leap_c [2];
  logic [14:0]         y25x [2];

  logic                v1, v2, v3;
  logic                en1, en2, en3;

  logic                s1_bad [2];
  logic [DAYS_W-1:0]   s1_p365 [2];
  logic [11:0]         s1_q4 [2];
  logic [7:0]          s1_q100 [2];
  logic [5:0]          s1_q400 [2];
  logic [YEAR_W-1:0]   s1_year [2];
  logic [9:0]          s1_y25 [2];
  logic [8:0]          s1_mdays [2];
  logic                s1_late [2];
  logic [DAY_W-1:0]    s1_dm1 [2];
  logic [TOD_W-1:0]    s1_tod [2];

  logic                s2_bad [2];
  logic [DAYS_W-1:0]   s2_base [2];
  logic [9:0]          s2_adj [2];
  logic [TOD_W-1:0]    s2_tod [2];

  logic                s3_bad;
  logic [DAYS_W-1:0]   s3_days [2];
  logic [TOD_W-1:0]    s3_tod [2];

  assign en3       = !v3 || !rsp_stall;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign req_stall = !en1;
  assign rsp_valid = v3;

  always_comb begin
    yr[0] = req.first_year;
    mo[0] = req.first_month;
    dy[0] = req.first_day;
    hr[0] = req.first_hour;
    mi[0] = req.first_minute;
    sc[0] = req.first_second;
    yr[1] = req.second_year;
    mo[1] = req.second_month;
    dy[1] = req.second_day;
    hr[1] = req.second_hour;
    mi[1] = req.second_minute;
    sc[1] = req.second_second;
    for (int l = 0; l < 2; l++) begin
      p[l]       = yr[l] - YEAR_W'(1);
      prod100[l] = 25'(p[l][YEAR_W-1:2]) * 25'(RECIP_25);
      prod400[l] = 23'(p[l][YEAR_W-1:4]) * 23'(RECIP_25);
      prod25[l]  = 27'(yr[l]) * 27'(RECIP_25);
      bad_c[l]   = (yr[l] == '0) || (17'(yr[l]) > 17'(MAX_YEAR)) ||
                   (mo[l] == '0) || (mo[l] > MONTH_W'(12)) || (dy[l] == '0) ||
                   (hr[l] > HOUR_W'(23)) || (mi[l] > MINUTE_W'(59)) ||
                   (sc[l] > SECOND_W'(59));
      y25x[l]    = 15'(s1_y25[l]) * 15'(25);
      leap_c[l]  = (s1_year[l][1:0] == 2'd0) &&
                   ((15'(s1_year[l]) != y25x[l]) || (s1_year[l][3:0] == 4'd0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= req_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (en1) begin
        s1_bad[l]   <= bad_c[l];
        s1_p365[l]  <= DAYS_W'(p[l]) * DAYS_W'(DAYS_PER_YEAR);
        s1_q4[l]    <= p[l][YEAR_W-1:2];
        s1_q100[l]  <= 8'(prod100[l] >> RECIP_25_SHIFT);
        s1_q400[l]  <= 6'(prod400[l] >> RECIP_25_SHIFT);
        s1_year[l]  <= yr[l];
        s1_y25[l]   <= 10'(prod25[l] >> RECIP_25_SHIFT);
        s1_mdays[l] <= days_before_month(mo[l]);
        s1_late[l]  <= mo[l] > MONTH_W'(2);
        s1_dm1[l]   <= dy[l] - DAY_W'(1);
        s1_tod[l]   <= TOD_W'(hr[l]) * TOD_W'(SECS_PER_HOUR) +
                       TOD_W'(mi[l]) * TOD_W'(SECS_PER_MIN) + TOD_W'(sc[l]);
      end
      if (en2) begin
        s2_bad[l]  <= s1_bad[l];
        s2_base[l] <= s1_p365[l] + DAYS_W'(s1_q4[l]) - DAYS_W'(s1_q100[l]) +
                      DAYS_W'(s1_q400[l]);
        s2_adj[l]  <= 10'(s1_mdays[l]) + 10'(s1_late[l] && leap_c[l]) +
                      10'(s1_dm1[l]);
        s2_tod[l]  <= s1_tod[l];
      end
      if (en3) begin
        s3_days[l] <= s2_base[l] + DAYS_W'(s2_adj[l]);
        s3_tod[l]  <= s2_tod[l];
      end
    end
    if (en3) begin
      s3_bad <= s2_bad[0] || s2_bad[1];
    end
  end

  always_comb begin
    rsp.bad    = s3_bad;
    rsp.days_a = s3_days[0];
    rsp.days_b = s3_days[1];
    rsp.tod_a  = s3_tod[0];
    rsp.tod_b  = s3_tod[1];
  end

endmodule

FILE: hdl/tse_diff.sv
// ----------------------------------------------------------------------------
// Difference stages
// Three register stages that form the absolute difference of two instants
// as whole days plus seconds of the day, borrowing a day when needed.
// ----------------------------------------------------------------------------
module tse_diff (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  tse_pkg::span_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output tse_pkg::delta_t rsp
);
  import tse_pkg::*;

  logic              v1, v2, v3;
  logic              en1, en2, en3;
  logic              neg;

  logic              s1_bad;
  logic [DAYS_W:0]   s1_dd;
  logic [TOD_W:0]    s1_dt;

  logic              s2_bad;
  logic [DAYS_W:0]   s2_d;
  logic [TOD_W:0]    s2_t;

  logic              s3_bad;
  logic [DAYS_W:0]   s3_d;
  logic [TOD_W:0]    s3_t;

  assign en3       = !v3 || !rsp_stall;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign req_stall = !en1;
  assign rsp_valid = v3;

  assign neg = s1_dd[DAYS_W] || ((s1_dd == '0) && s1_dt[TOD_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= req_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_bad <= req.bad;
      s1_dd  <= {1'b0, req.days_b} - {1'b0, req.days_a};
      s1_dt  <= {1'b0, req.tod_b} - {1'b0, req.tod_a};
    end
    if (en2) begin
      s2_bad <= s1_bad;
      s2_d   <= neg ? ('0 - s1_dd) : s1_dd;
      s2_t   <= neg ? ('0 - s1_dt) : s1_dt;
    end
    if (en3) begin
      s3_bad <= s2_bad;
      if (s2_t[TOD_W]) begin
        s3_d <= s2_d - (DAYS_W+1)'(1);
        s3_t <= s2_t + (TOD_W+1)'(SECS_PER_DAY);
      end else begin
        s3_d <= s2_d;
        s3_t <= s2_t;
      end
    end
  end

  always_comb begin
    rsp.bad  = s3_bad;
    rsp.days = s3_d[DAYS_W-1:0];
    rsp.tod  = s3_t[TOD_W-1:0];
  end

endmodule

FILE: hdl/tse_hms.sv
// ----------------------------------------------------------------------------
// Hours, minutes and seconds stages
// Four register stages that split a difference of days and seconds into
// whole hours, minutes and seconds; the last stage is the result register.
// ----------------------------------------------------------------------------
module tse_hms (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  tse_pkg::delta_t   req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output tse_pkg::elapsed_t rsp
);
  import tse_pkg::*;

  logic                v1, v2, v3, v4;
  logic                en1, en2, en3, en4;
  logic [25:0]         prod_h;
  logic [20:0]         prod_m;

  logic                s1_bad;
  logic [HOURS_W-1:0]  s1_hd;
  logic [5:0]          s1_th;
  logic [TOD_W-1:0]    s1_t;

  logic                s2_bad;
  logic [HOURS_W-1:0]  s2_hours;
  logic [REM_W-1:0]    s2_rem;

  logic                s3_bad;
  logic [HOURS_W-1:0]  s3_hours;
  logic [REM_W-1:0]    s3_rem;
  logic [MINUTE_W-1:0] s3_min;

  elapsed_t            s4;

  assign en4       = !v4 || !rsp_stall;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign req_stall = !en1;
  assign rsp_valid = v4;
  assign rsp       = s4;

  assign prod_h = 26'(req.tod[TOD_W-1:4]) * 26'(RECIP_225);
  assign prod_m = 21'(s2_rem[REM_W-1:2]) * 21'(RECIP_15);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= req_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_bad <= req.bad;
      s1_hd  <= HOURS_W'(req.days) * HOURS_W'(HOURS_PER_DAY);
      s1_th  <= 6'(prod_h >> RECIP_225_SHIFT);
      s1_t   <= req.tod;
    end
    if (en2) begin
      s2_bad   <= s1_bad;
      s2_hours <= s1_hd + HOURS_W'(s1_th);
      s2_rem   <= REM_W'(s1_t - TOD_W'(s1_th) * TOD_W'(SECS_PER_HOUR));
    end
    if (en3) begin
      s3_bad   <= s2_bad;
      s3_hours <= s2_hours;
      s3_rem   <= s2_rem;
      s3_min   <= MINUTE_W'(prod_m >> RECIP_15_SHIFT);
    end
    if (en4) begin
      if (s3_bad) begin
        s4.elapsed_hours   <= '0;
        s4.elapsed_minutes <= '0;
        s4.elapsed_seconds <= '0;
        s4.invalid         <= 1'b1;
      end else begin
        s4.elapsed_hours   <= s3_hours;
        s4.elapsed_minutes <= s3_min;
        s4.elapsed_seconds <= SECOND_W'(s3_rem - REM_W'(s3_min) * REM_W'(SECS_PER_MIN));
        s4.invalid         <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/timestamp_elapsed_hms.sv
// ----------------------------------------------------------------------------
// Elapsed time between two timestamps
// Each request carries two Gregorian timestamps; each result gives the
// absolute time between them as whole hours, minutes and seconds.
//
// A request is taken on the stamps channel at a rising edge where
// stamps_valid is high and stamps_stall is low; a result leaves on the
// elapsed channel under the same rule with elapsed_valid and elapsed_stall.
// Every request gives exactly one result, in order. A request with any
// field out of range (the day is checked only for zero) gives invalid set
// and zero in the other fields. The pipeline is ten register stages deep,
// and one request is taken in every cycle while no stall holds it. Each
// stage carries its own valid bit and holds while the stage after it is
// full and held, so a stalled receiver freezes only the full stages and
// empty stages upstream keep filling. Reset empties the pipeline; no
// results are pending afterwards.
// ----------------------------------------------------------------------------
module timestamp_elapsed_hms #(
  parameter int unsigned MAX_YEAR = tse_pkg::MAX_YEAR
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              stamps_valid,
  output logic              stamps_stall,
  input  tse_pkg::stamps_t  stamps,
  output logic              elapsed_valid,
  input  logic              elapsed_stall,
  output tse_pkg::elapsed_t elapsed
);
  import tse_pkg::*;

  logic   span_valid, span_stall;
  span_t  span;
  logic   delta_valid, delta_stall;
  delta_t delta;

  tse_days #(
    .MAX_YEAR (MAX_YEAR)
  ) u_days (
    .clk       (clk),
    .rst       (rst),
    .req_valid (stamps_valid),
    .req_stall (stamps_stall),
    .req       (stamps),
    .rsp_valid (span_valid),
    .rsp_stall (span_stall),
    .rsp       (span)
  );

  tse_diff u_diff (
    .clk       (clk),
    .rst       (rst),
    .req_valid (span_valid),
    .req_stall (span_stall),
    .req       (span),
    .rsp_valid (delta_valid),
    .rsp_stall (delta_stall),
    .rsp       (delta)
  );

  tse_hms u_hms (
    .clk       (clk),
    .rst       (rst),
    .req_valid (delta_valid),
    .req_stall (delta_stall),
    .req       (delta),
    .rsp_valid (elapsed_valid),
    .rsp_stall (elapsed_stall),
    .rsp       (elapsed)
  );

endmodule
